// ----- rtl/psca_pkg.sv -----
package psca_pkg;

  // number of command sources, rank 0 is highest priority
  localparam int NUM_SOURCES = 8;
  localparam int IDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  // field widths
  localparam int RANK_W = 3;
  localparam int TIME_W = 32;
  localparam int CMD_W = 16;
  localparam int CMDS_W = 4 * CMD_W;
  localparam int CAL_W = 49;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = CAL_W;

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS = RANK_W + TIME_W + CMDS_W;
  localparam int IN_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = 2 * (1 + 16 + 16) + 2 * (1 + 15 + 16);
  localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

  // q1.14 unity
  localparam logic signed [CMD_W-1:0] Q_ONE = 16'sd16384;
  localparam logic signed [CMD_W-1:0] Q_MINUS_ONE = -16'sd16384;

  // operation codes on tuser
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLED = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_PRESENT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_PRESENT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THROTTLE_CAL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STEERING_CAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_CAL = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BACK_CAL = 3'd7;

  // reset values: centre 1500, min 1000, max 2000, not reversed
  localparam logic [TIME_W-1:0] MAX_AGE_RESET = 32'd100;
  localparam logic [CAL_W-1:0] CAL_RESET = 49'd8590000129500;

  // channel numbers
  localparam logic [1:0] CH_THROTTLE = 2'd0;
  localparam logic [1:0] CH_STEERING = 2'd1;
  localparam logic [1:0] CH_FRONT = 2'd2;
  localparam logic [1:0] CH_BACK = 2'd3;
  localparam int NUM_CH = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MAP,
    ST_DONE
  } psca_state_t;

  typedef struct packed {
    logic [TIME_W-1:0] max_age;
    logic coupled;
    logic front_present;
    logic back_present;
    logic [CAL_W-1:0] throttle_cal;
    logic [CAL_W-1:0] steering_cal;
    logic [CAL_W-1:0] front_cal;
    logic [CAL_W-1:0] back_cal;
  } psca_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic entry_wr;
    logic tick_start;
    logic scan_en;
    logic [IDX_W-1:0] scan_idx;
    logic map_en;
    logic [1:0] map_ch;
    logic fin_en;
    logic [1:0] fin_ch;
    logic out_load;
  } psca_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
  } psca_sts_t;

endpackage

// ----- rtl/priority_servo_command_arbiter_top.sv -----
// Priority servo command arbiter. Keeps the latest command of each source,
// indexed by priority rank (0 highest). An update transaction (tuser op 0)
// writes the entry of its rank and gives no result. A tick
// transaction (tuser op 1) scans the table one entry per cycle in rank order,
// picking per channel the first fresh value within -1..+1, then maps the four
// channels to quarter-microsecond servo pulses through one shared
// multiplier: the scan of all NUM_SOURCES entries, then the map of the four
// channels, then the load of the result; the next transaction is taken only
// after the load. The load waits while a previous result still waits in the
// output register. The result sits in an output register, so updates are
// accepted while a result waits. Configuration is written through cfg_we;
// the user must write it only while idle, which the block does not enforce.
module priority_servo_command_arbiter_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // source_rank[2:0], time_now[34:3], cmd_throttle[50:35],
  // cmd_steering[66:51], cmd_front_brake[82:67], cmd_back_brake[98:83]
  input  logic [psca_pkg::IN_W-1:0]        s_axis_tdata,
  // op[0]
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // throttle_valid[0], throttle_value[16:1], throttle_pulse[32:17],
  // steering_valid[33], steering_value[49:34], steering_pulse[65:50],
  // front_valid[66], front_value[81:67], front_pulse[97:82],
  // back_valid[98], back_value[113:99], back_pulse[129:114]
  output logic [psca_pkg::OUT_W-1:0]       m_axis_tdata,
  input  logic                             cfg_we,
  input  logic [psca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psca_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import psca_pkg::*;

  psca_cfg_t cfg;
  psca_cmd_t cmd;
  psca_sts_t sts;

  // configuration registers
  psca_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // sequencer
  psca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser[0]),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // table, scan and pulse mapping
  psca_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_data   (s_axis_tdata),
    .sts       (sts),
    .out_data  (m_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

endmodule

// ----- rtl/psca_cfg.sv -----
module psca_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [psca_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [psca_pkg::CFG_DATA_W-1:0]  cfg_data,
  output psca_pkg::psca_cfg_t              cfg
);
  import psca_pkg::*;

  // register file; the user must write it only while the block is idle, which the block itself does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_age <= MAX_AGE_RESET;
      cfg.coupled <= 1'b0;
      cfg.front_present <= 1'b0;
      cfg.back_present <= 1'b0;
      cfg.throttle_cal <= CAL_RESET;
      cfg.steering_cal <= CAL_RESET;
      cfg.front_cal <= CAL_RESET;
      cfg.back_cal <= CAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_AGE: cfg.max_age <= cfg_data[TIME_W-1:0];
        CFG_COUPLED: cfg.coupled <= cfg_data[0];
        CFG_FRONT_PRESENT: cfg.front_present <= cfg_data[0];
        CFG_BACK_PRESENT: cfg.back_present <= cfg_data[0];
        CFG_THROTTLE_CAL: cfg.throttle_cal <= cfg_data;
        CFG_STEERING_CAL: cfg.steering_cal <= cfg_data;
        CFG_FRONT_CAL: cfg.front_cal <= cfg_data;
        CFG_BACK_CAL: cfg.back_cal <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/psca_ctrl.sv -----
module psca_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_ready,
  input  psca_pkg::psca_sts_t  sts,
  output psca_pkg::psca_cmd_t  cmd
);
  import psca_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SOURCES - 1);
  localparam logic [2:0] MAP_LAST = 3'(NUM_CH);

  psca_state_t state, state_next;
  logic [IDX_W-1:0] scan_cnt, scan_cnt_next;
  logic [2:0] map_cnt, map_cnt_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scan_cnt <= '0;
      map_cnt <= '0;
    end else begin
      state <= state_next;
      scan_cnt <= scan_cnt_next;
      map_cnt <= map_cnt_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    scan_cnt_next = scan_cnt;
    map_cnt_next = map_cnt;
    in_ready = 1'b0;
    cmd = '0;
    cmd.scan_idx = scan_cnt;
    cmd.map_ch = map_cnt[1:0];
    cmd.fin_ch = 2'(map_cnt - 3'd1);
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_TICK) begin
            cmd.tick_start = 1'b1;
            scan_cnt_next = '0;
            state_next = ST_SCAN;
          end else begin
            cmd.entry_wr = 1'b1;
          end
        end
      end
      // one table entry per cycle in rank order
      ST_SCAN: begin
        cmd.scan_en = 1'b1;
        if (scan_cnt == LAST_IDX) begin
          map_cnt_next = '0;
          state_next = ST_MAP;
        end else begin
          scan_cnt_next = scan_cnt + 1'b1;
        end
      end
      // multiply for channel n overlaps the finish of channel n-1
      ST_MAP: begin
        cmd.map_en = (map_cnt != MAP_LAST);
        cmd.fin_en = (map_cnt != 3'd0);
        if (map_cnt == MAP_LAST) begin
          state_next = ST_DONE;
        end else begin
          map_cnt_next = map_cnt + 3'd1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/psca_dp.sv -----
module psca_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  psca_pkg::psca_cmd_t         cmd,
  input  psca_pkg::psca_cfg_t         cfg,
  input  logic [psca_pkg::IN_W-1:0]   in_data,
  output psca_pkg::psca_sts_t         sts,
  output logic [psca_pkg::OUT_W-1:0]  out_data,
  output logic                        out_valid,
  input  logic                        out_ready
);
  import psca_pkg::*;

  // input transaction fields
  logic [RANK_W-1:0] in_rank;
  logic [TIME_W-1:0] in_time;
  logic [CMDS_W-1:0] in_cmds;

  assign in_rank = in_data[RANK_W-1:0];
  assign in_time = in_data[RANK_W +: TIME_W];
  assign in_cmds = in_data[RANK_W + TIME_W +: CMDS_W];

  // command table
  logic [NUM_SOURCES-1:0] entry_valid;
  logic [TIME_W-1:0] entry_stamp [NUM_SOURCES];
  logic [CMDS_W-1:0] entry_cmds [NUM_SOURCES];
  logic rank_ok;

  assign rank_ok = (32'(in_rank) < 32'(NUM_SOURCES));

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (cmd.entry_wr && rank_ok) begin
      entry_valid[IDX_W'(in_rank)] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.entry_wr && rank_ok) begin
      entry_stamp[IDX_W'(in_rank)] <= in_time;
      entry_cmds[IDX_W'(in_rank)] <= in_cmds;
    end
  end

  // scan: freshness of the selected entry
  logic [TIME_W-1:0] now_reg;
  logic [TIME_W-1:0] age;
  logic fresh;
  logic [CMDS_W-1:0] sel_cmds;
  logic [NUM_CH-1:0] found;
  logic signed [CMD_W-1:0] val [NUM_CH];

  assign age = now_reg - entry_stamp[cmd.scan_idx];
  assign fresh = entry_valid[cmd.scan_idx] && (age < cfg.max_age);
  assign sel_cmds = entry_cmds[cmd.scan_idx];

  // first fresh in-range value per channel wins
  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      now_reg <= in_time;
      found <= '0;
      for (int c = 0; c < NUM_CH; c++) begin
        val[c] <= '0;
      end
    end else if (cmd.scan_en && fresh) begin
      for (int c = 0; c < NUM_CH; c++) begin
        if (!found[c] && ($signed(sel_cmds[c*CMD_W +: CMD_W]) >= Q_MINUS_ONE) &&
            ($signed(sel_cmds[c*CMD_W +: CMD_W]) <= Q_ONE)) begin
          found[c] <= 1'b1;
          val[c] <= $signed(sel_cmds[c*CMD_W +: CMD_W]);
        end
      end
    end
  end

  // clamps and issue flags
  logic signed [CMD_W-1:0] cval [NUM_CH];
  logic [NUM_CH-1:0] issue;

  always_comb begin
    cval[CH_THROTTLE] = (!cfg.coupled && val[CH_THROTTLE] < 0) ? '0 : val[CH_THROTTLE];
    cval[CH_STEERING] = val[CH_STEERING];
    cval[CH_FRONT] = (val[CH_FRONT] < 0) ? '0 : val[CH_FRONT];
    cval[CH_BACK] = (val[CH_BACK] < 0) ? '0 : val[CH_BACK];
    issue[CH_THROTTLE] = found[CH_THROTTLE];
    issue[CH_STEERING] = found[CH_STEERING];
    issue[CH_FRONT] = found[CH_FRONT] & cfg.front_present;
    issue[CH_BACK] = found[CH_BACK] & cfg.back_present;
  end

  // pulse map, first half: span selection and multiply
  logic [CAL_W-1:0] cal_sel;
  logic [15:0] centre, cal_lo, cal_hi;
  logic signed [17:0] q_raw, q;
  logic signed [16:0] span;
  logic signed [34:0] prod;
  logic [15:0] centre_reg;

  always_comb begin
    unique case (cmd.map_ch)
      CH_THROTTLE: cal_sel = cfg.throttle_cal;
      CH_STEERING: cal_sel = cfg.steering_cal;
      CH_FRONT: cal_sel = cfg.front_cal;
      CH_BACK: cal_sel = cfg.back_cal;
      default: cal_sel = cfg.throttle_cal;
    endcase
    centre = cal_sel[15:0];
    cal_lo = cal_sel[31:16];
    cal_hi = cal_sel[47:32];
    q_raw = {{2{cval[cmd.map_ch][CMD_W-1]}}, cval[cmd.map_ch]};
    q = cal_sel[48] ? -q_raw : q_raw;
    span = (q > 0) ? $signed({1'b0, cal_hi} - {1'b0, centre})
                   : $signed({1'b0, centre} - {1'b0, cal_lo});
  end

  always_ff @(posedge clk) begin
    if (cmd.map_en) begin
      prod <= q * span;
      centre_reg <= centre;
    end
  end

  // pulse map, second half: offset, scale by 1/4096 and saturate
  logic signed [36:0] num;
  logic [15:0] pulse_new;
  logic [15:0] pulse [NUM_CH];

  always_comb begin
    num = $signed({7'd0, centre_reg, 14'd0}) + $signed({{2{prod[34]}}, prod});
    if (num[36]) begin
      pulse_new = '0;
    end else if (|num[35:28]) begin
      pulse_new = 16'hFFFF;
    end else begin
      pulse_new = num[27:12];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      pulse[cmd.fin_ch] <= pulse_new;
    end
  end

  // result register
  assign sts.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {
        (OUT_W - OUT_BITS)'(0),
        issue[CH_BACK] ? pulse[CH_BACK] : 16'd0,
        issue[CH_BACK] ? cval[CH_BACK][14:0] : 15'd0,
        issue[CH_BACK],
        issue[CH_FRONT] ? pulse[CH_FRONT] : 16'd0,
        issue[CH_FRONT] ? cval[CH_FRONT][14:0] : 15'd0,
        issue[CH_FRONT],
        issue[CH_STEERING] ? pulse[CH_STEERING] : 16'd0,
        issue[CH_STEERING] ? cval[CH_STEERING] : 16'sd0,
        issue[CH_STEERING],
        issue[CH_THROTTLE] ? pulse[CH_THROTTLE] : 16'd0,
        issue[CH_THROTTLE] ? cval[CH_THROTTLE] : 16'sd0,
        issue[CH_THROTTLE]
      };
    end
  end

endmodule
